/* hdl/lirs_pkg.sv */
// Linear interpolation resampler: shared configuration constants.
// No dependencies; used by the resampler top level.
`default_nettype none
package lirs_pkg;

  // Position fraction bits (Q5.16 step and offset)
  localparam int FRAC_BITS = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 21;

  // Register widths
  localparam int STEP_W  = 21;
  localparam int COUNT_W = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_RATIO = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_COUNT  = 1'b1;

endpackage
`default_nettype wire

/* hdl/lirs_lerp.sv */
// Linear interpolation datapath: prev + floor(frac * diff), frac in fixed point.
// Purely combinational; no package dependencies.
`default_nettype none
module lirs_lerp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic        [FRAC_BITS:0]    frac,
  input  logic signed [SAMPLE_WIDTH:0] diff,
  input  logic signed [SAMPLE_WIDTH-1:0] prev,
  output logic signed [SAMPLE_WIDTH-1:0] value
);

  localparam int PROD_W = SAMPLE_WIDTH + FRAC_BITS + 3;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;

  always_comb begin
    prod    = PROD_W'($signed({1'b0, frac})) * PROD_W'(diff);
    // arithmetic shift floors toward minus infinity
    shifted = prod >>> FRAC_BITS;
    // result lies between the two samples, so the low bits are exact
    value   = SAMPLE_WIDTH'(shifted) + prev;
  end

endmodule
`default_nettype wire

/* hdl/linear_interpolation_resampler_unit.sv */
// Results are registered on out_* from the work stage, which registers each accepted input sample.
// Throughput: an input sample holds the work stage until it has covered its k result positions
// (k <= 1 for step >= 1.0, up to 16 at step 1/16); the single interpolation
// multiplier and result register produce one result per cycle while out_stall is low.
// Reset (synchronous, rst_n low): state as after a block start, step_ratio 1.0,
// out_count 0, no result pending.
`default_nettype none
module linear_interpolation_resampler_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                                in_block_start,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_value,
  output logic                                out_last_in_run,
  output logic                                out_block_done,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lirs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lirs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int OFF_W = lirs_pkg::FRAC_BITS + 5;
  localparam int CMP_W = (lirs_pkg::STEP_W > OFF_W) ? lirs_pkg::STEP_W : OFF_W;
  localparam logic [OFF_W-1:0] UNIT     = OFF_W'(64'd1 << lirs_pkg::FRAC_BITS);
  localparam logic [OFF_W-1:0] STEP_MIN = UNIT >> 4;
  localparam logic [OFF_W-1:0] STEP_MAX = UNIT << 4;

  // configuration
  logic [lirs_pkg::STEP_W-1:0]  step_ratio_r;
  logic [lirs_pkg::COUNT_W-1:0] out_count_r;

  // block state
  logic signed [SAMPLE_WIDTH-1:0] prev_r, prev_nxt;
  logic [OFF_W-1:0]               offset_r, offset_nxt;
  logic [lirs_pkg::COUNT_W-1:0]   emitted_r, emitted_nxt;

  // work stage
  logic                           wk_valid_r, wk_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] cur_r, cur_nxt;
  logic signed [SAMPLE_WIDTH:0]   diff_r, diff_nxt;

  // result register
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] value_r;
  logic                           last_r;
  logic                           done_r;

  logic [CMP_W-1:0]               step_ext;
  logic [OFF_W-1:0]               step_sat;
  logic                           iter;
  logic                           emit;
  logic [OFF_W-1:0]               off_add;
  logic                           fin;
  logic                           slot_free;
  logic                           adv;
  logic                           retire;
  logic                           in_acc;
  logic [lirs_pkg::COUNT_W-1:0]   emitted_inc;
  logic                           blk_done;
  logic signed [SAMPLE_WIDTH-1:0] prev_base;
  logic signed [SAMPLE_WIDTH-1:0] prev_eff;
  logic [OFF_W-1:0]               off_base;
  logic [lirs_pkg::COUNT_W-1:0]   em_base;
  logic signed [SAMPLE_WIDTH-1:0] lerp_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ratio_r <= lirs_pkg::STEP_W'(UNIT);
      out_count_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lirs_pkg::CFG_STEP_RATIO: step_ratio_r <= cfg_data[lirs_pkg::STEP_W-1:0];
        lirs_pkg::CFG_OUT_COUNT:  out_count_r  <= cfg_data[lirs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    step_ext = CMP_W'(step_ratio_r);
    if (step_ext < CMP_W'(STEP_MIN))
      step_sat = STEP_MIN;
    else if (step_ext > CMP_W'(STEP_MAX))
      step_sat = STEP_MAX;
    else
      step_sat = OFF_W'(step_ext);

    iter        = offset_r <= UNIT;
    emitted_inc = emitted_r + lirs_pkg::COUNT_W'(1);
    blk_done    = emitted_inc == out_count_r;
    emit        = wk_valid_r && iter && (emitted_r < out_count_r);
    off_add     = iter ? (offset_r + step_sat) : offset_r;
    fin         = off_add > UNIT;
    slot_free   = !out_valid_r || !out_stall;
    adv         = wk_valid_r && (!emit || slot_free);
    retire      = adv && fin;
    in_stall    = wk_valid_r && !retire;
    in_acc      = in_valid && !in_stall;

    prev_base = retire ? cur_r : prev_r;
    if (retire)
      off_base = off_add - UNIT;
    else if (adv)
      off_base = off_add;
    else
      off_base = offset_r;
    em_base = (adv && emit) ? emitted_inc : emitted_r;

    prev_eff = in_block_start ? '0 : prev_base;

    if (in_acc && in_block_start) begin
      prev_nxt    = '0;
      offset_nxt  = UNIT;
      emitted_nxt = '0;
    end else begin
      prev_nxt    = prev_base;
      offset_nxt  = off_base;
      emitted_nxt = em_base;
    end

    if (in_acc) begin
      wk_valid_nxt = 1'b1;
      cur_nxt      = in_sample;
      diff_nxt     = (SAMPLE_WIDTH+1)'(in_sample) - (SAMPLE_WIDTH+1)'(prev_eff);
    end else begin
      wk_valid_nxt = retire ? 1'b0 : wk_valid_r;
      cur_nxt      = cur_r;
      diff_nxt     = diff_r;
    end
  end

  lirs_lerp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (lirs_pkg::FRAC_BITS)
  ) u_lerp (
    .frac  (offset_r[lirs_pkg::FRAC_BITS:0]),
    .diff  (diff_r),
    .prev  (prev_r),
    .value (lerp_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      offset_r   <= UNIT;
      emitted_r  <= '0;
      wk_valid_r <= 1'b0;
    end else begin
      prev_r     <= prev_nxt;
      offset_r   <= offset_nxt;
      emitted_r  <= emitted_nxt;
      wk_valid_r <= wk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    diff_r <= diff_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && slot_free) begin
      value_r <= lerp_value;
      last_r  <= fin || blk_done;
      done_r  <= blk_done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = value_r;
  assign out_last_in_run = last_r;
  assign out_block_done  = done_r;

  // offset stays in (0, 16] sample units
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    (offset_r != '0) && (offset_r <= STEP_MAX))
    else $error("position offset out of range");

  // the result that completes a block also ends its run
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_done) |-> out_last_in_run)
    else $error("block_done without last_in_run");

  // a sample that covers no result position retires without stalling the input channel
  a_skip_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (wk_valid_r && (offset_r > UNIT)) |-> !in_stall)
    else $error("sample without results held the work stage");

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench for linear_interpolation_resampler_unit: directed and random sample streams.
// A scoreboard class predicts each interpolated result in fixed point and checks it.
// Depends on lirs_pkg and the resampler top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W = lirs_pkg::FRAC_BITS;
  localparam longint ONE = longint'(1) << FRAC_W;
  localparam longint STEP_FLOOR = ONE >> 4;
  localparam longint STEP_CEIL = ONE << 4;
  localparam int MAX_RUN = 16;
  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 18;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last_in_run;
    logic                       block_done;
  } result_t;

  class resampler_scoreboard;
    bit [lirs_pkg::STEP_W-1:0]  step_ratio;
    bit [lirs_pkg::COUNT_W-1:0] out_count;
    longint                     prev_sample;
    longint                     pos_offset;
    bit [lirs_pkg::COUNT_W-1:0] emitted;
    result_t                    pending_results[$];
    int                         fail_count;

    function new();
      step_ratio = lirs_pkg::STEP_W'(ONE);
      out_count = '0;
      prev_sample = 0;
      pos_offset = ONE;
      emitted = '0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [lirs_pkg::CFG_INDEX_W-1:0] idx,
                            logic [lirs_pkg::CFG_DATA_W-1:0] data);
      if (idx == lirs_pkg::CFG_STEP_RATIO) begin
        step_ratio = data[lirs_pkg::STEP_W-1:0];
      end else if (idx == lirs_pkg::CFG_OUT_COUNT) begin
        out_count = data[lirs_pkg::COUNT_W-1:0];
      end
    endfunction

    // Every pending position in (previous, current] gives one result until the block is complete.
    function void interpolate_sample(logic signed [SAMPLE_W-1:0] smp, logic block_start);
      longint  cur;
      longint  diff;
      longint  step;
      longint  prod;
      int      n;
      result_t r;
      result_t run[$];
      cur = longint'(smp);
      step = longint'(step_ratio);
      if (step < STEP_FLOOR) step = STEP_FLOOR;
      if (step > STEP_CEIL) step = STEP_CEIL;
      if (block_start) begin
        pos_offset = ONE;
        prev_sample = 0;
        emitted = '0;
      end
      diff = cur - prev_sample;
      n = 0;
      while (pos_offset <= ONE && n < MAX_RUN) begin
        // once the block is complete, positions still advance but nothing comes out
        if (emitted < out_count) begin
          prod = pos_offset * diff;
          r.value = SAMPLE_W'(prev_sample + (prod >>> FRAC_W));
          emitted = emitted + 1'b1;
          r.last_in_run = 1'b0;
          r.block_done = (emitted == out_count);
          run.push_back(r);
          n++;
        end
        pos_offset += step;
      end
      if (pos_offset <= ONE) pos_offset = ONE + 1;
      pos_offset -= ONE;
      prev_sample = cur;
      foreach (run[i]) begin
        r = run[i];
        r.last_in_run = (i == run.size() - 1);
        pending_results.push_back(r);
      end
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] value, logic last_in_run,
                               logic block_done);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d last_in_run %0b block_done %0b",
               value, last_in_run, block_done);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (value !== exp_r.value) begin
          $error("value: expected %0d, got %0d", exp_r.value, value);
          fail_count++;
        end
        if (last_in_run !== exp_r.last_in_run) begin
          $error("last_in_run: expected %0b, got %0b", exp_r.last_in_run, last_in_run);
          fail_count++;
        end
        if (block_done !== exp_r.block_done) begin
          $error("block_done: expected %0b, got %0b", exp_r.block_done, block_done);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [SAMPLE_W-1:0]          in_sample;
  logic                                in_block_start;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]          out_value;
  logic                                out_last_in_run;
  logic                                out_block_done;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [lirs_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [lirs_pkg::CFG_DATA_W-1:0]     cfg_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  resampler_scoreboard sb;

  linear_interpolation_resampler_unit #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .in_block_start(in_block_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .out_last_in_run(out_last_in_run),
    .out_block_done(out_block_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.interpolate_sample(in_sample, in_block_start);
      if (out_valid && !out_stall) sb.check_result(out_value, out_last_in_run, out_block_done);
    end
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic bs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = smp;
    in_block_start = bs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    // samples that cause no result may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(logic [lirs_pkg::CFG_INDEX_W-1:0] idx, int unsigned data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = lirs_pkg::CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_W'(int'($urandom_range(64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int          sent;
    int          run_len;
    int unsigned step_val;
    int unsigned count_val;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_block_start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lirs_pkg::CFG_STEP_RATIO;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // No block start yet: the stream acts as if a block opened at reset.
    write_config(lirs_pkg::CFG_STEP_RATIO, 32768);
    write_config(lirs_pkg::CFG_OUT_COUNT, 5);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shFFFF, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b0);
    wait_for_drain();

    // Finest step, then a count below what the block already emitted.
    write_config(lirs_pkg::CFG_STEP_RATIO, 4096);
    write_config(lirs_pkg::CFG_OUT_COUNT, 40);
    send_sample(16'sd100, 1'b1);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    wait_for_drain();
    write_config(lirs_pkg::CFG_OUT_COUNT, 2);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd7, 1'b1);
    send_sample(16'sh8000, 1'b0);
    wait_for_drain();

    // Step outside its range saturates at both ends.
    write_config(lirs_pkg::CFG_STEP_RATIO, 0);
    write_config(lirs_pkg::CFG_OUT_COUNT, 65535);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    wait_for_drain();
    write_config(lirs_pkg::CFG_STEP_RATIO, 2097151);
    send_sample(-16'sd1234, 1'b1);
    send_sample(16'sd4321, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    wait_for_drain();

    // Zero count: nothing comes out at all.
    write_config(lirs_pkg::CFG_STEP_RATIO, 1048576);
    write_config(lirs_pkg::CFG_OUT_COUNT, 0);
    send_sample(16'sd300, 1'b1);
    send_sample(-16'sd300, 1'b0);
    wait_for_drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 84;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 84;
        end
        default: begin
          idle_pct = 25;
          stall_pct = 25;
        end
      endcase
      case ($urandom_range(9))
        0: step_val = 4096;
        1: step_val = 1048576;
        2: step_val = $urandom_range(1) ? $urandom_range(4095)
                                         : $urandom_range(2097151, 1048577);
        3, 4, 5: step_val = $urandom_range(65536, 4096);
        default: step_val = $urandom_range(1048576, 65536);
      endcase
      case ($urandom_range(11))
        0: count_val = 0;
        1: count_val = 65535;
        default: count_val = $urandom_range(48, 1);
      endcase
      write_config(lirs_pkg::CFG_STEP_RATIO, step_val);
      write_config(lirs_pkg::CFG_OUT_COUNT, count_val);

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          run_len = $urandom_range(12, 1);
          send_sample(random_sample(), 1'b1);
          sent++;
          repeat (run_len) begin
            send_sample(random_sample(), 1'b0);
            sent++;
          end
        end else begin
          // loose samples with a random block-start bit
          repeat ($urandom_range(3, 1)) begin
            send_sample(random_sample(), 1'($urandom_range(1)));
            sent++;
          end
        end
        if ($urandom_range(7) == 0) wait_for_drain();
      end
      wait_for_drain();
    end

    if (sb.fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* linear_interpolation_resampler_unit.f */
hdl/lirs_pkg.sv
hdl/lirs_lerp.sv
hdl/linear_interpolation_resampler_unit.sv
test/tb_top.sv
